@@ rtl/core/kescan_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kescan_pkg
// Shared constants, event codes and controller/datapath interface types for
// the key matrix and rotary encoder event scanner.
// ----------------------------------------------------------------------------
package kescan_pkg;

    localparam int QUEUE_DEPTH = 128;
    localparam int SCAN_ROWS   = 4;
    localparam int SCAN_COLS   = 4;

    localparam int KEY_SLOTS = 16;
    localparam int NUM_KEYS  = (SCAN_ROWS * SCAN_COLS < KEY_SLOTS) ?
                               SCAN_ROWS * SCAN_COLS : KEY_SLOTS;
    localparam int KEY_IW    = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

    localparam int Q_AW = $clog2(QUEUE_DEPTH);
    localparam int QC_W = $clog2(QUEUE_DEPTH + 1);

    localparam int CODE_W  = 5;
    localparam int KIND_W  = 2;
    localparam int ENTRY_W = CODE_W + KIND_W;
    localparam int LEFT_W  = 8;
    localparam int TIME_W  = 32;
    localparam int CFG_W   = 16;
    localparam int CFG_AW  = 3;

    // register indexes
    localparam logic [CFG_AW-1:0] REG_KEY_MASK   = 3'd0;
    localparam logic [CFG_AW-1:0] REG_HOLD_TIME  = 3'd1;
    localparam logic [CFG_AW-1:0] REG_LONG_TIME  = 3'd2;
    localparam logic [CFG_AW-1:0] REG_ENC_PULSES = 3'd3;
    localparam logic [CFG_AW-1:0] REG_EVT_ENABLE = 3'd4;

    // reset values
    localparam logic [15:0] RST_KEY_MASK   = 16'd4991;
    localparam logic [15:0] RST_HOLD_TIME  = 16'd100;
    localparam logic [15:0] RST_LONG_TIME  = 16'd500;
    localparam logic [1:0]  RST_ENC_PULSES = 2'd2;
    localparam logic [2:0]  RST_EVT_ENABLE = 3'd1;

    // event kinds and encoder codes
    localparam logic [KIND_W-1:0] KIND_PRESS   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LONG    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd2;
    localparam logic [CODE_W-1:0] CODE_LEFT    = 5'd16;
    localparam logic [CODE_W-1:0] CODE_RIGHT   = 5'd17;

    // item operations
    localparam logic OP_SCAN = 1'b0;
    localparam logic OP_POP  = 1'b1;

    typedef struct packed {
        logic              latch;     // capture the input transaction
        logic              key_step;  // examine one key
        logic [KEY_IW-1:0] key_idx;
        logic              enc_step;  // update the encoder decoder
        logic              pop_rd;    // read queue head, advance pointers
        logic              out_load;  // load the output register
    } kescan_cmd_t;

    typedef struct packed {
        logic out_free;  // output register empty or draining this cycle
    } kescan_stat_t;

endpackage

@@ rtl/core/kescan_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kescan_ctrl
// Sequencer: accepts one transaction at a time, walks the keys one per
// cycle, steps the encoder, or runs the queue pop (read, then output load).
// ----------------------------------------------------------------------------
module kescan_ctrl
    import kescan_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         in_valid,
    input  logic         in_op,
    output logic         in_ready,
    input  kescan_stat_t stat,
    output kescan_cmd_t  cmd
);

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_KEY     = 3'd1;
    localparam logic [2:0] ST_ENC     = 3'd2;
    localparam logic [2:0] ST_POP_RD  = 3'd3;
    localparam logic [2:0] ST_POP_OUT = 3'd4;

    localparam logic [KEY_IW-1:0] LAST_KEY = KEY_IW'(NUM_KEYS - 1);

    logic [2:0]        state_reg, state_next;
    logic [KEY_IW-1:0] idx_reg, idx_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        cmd          = '0;
        cmd.key_idx  = idx_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    cmd.latch = 1'b1;
                    idx_next  = '0;
                    state_next = (in_op == OP_POP) ? ST_POP_RD : ST_KEY;
                end
            end
            ST_KEY: begin
                cmd.key_step = 1'b1;
                if (idx_reg == LAST_KEY) begin
                    state_next = ST_ENC;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_ENC: begin
                cmd.enc_step = 1'b1;
                state_next   = ST_IDLE;
            end
            ST_POP_RD: begin
                cmd.pop_rd = 1'b1;
                state_next = ST_POP_OUT;
            end
            ST_POP_OUT: begin
                // hold the popped entry until the output register frees up
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

endmodule

@@ rtl/core/kescan_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kescan_dp
// Datapath: configuration registers, per-key tracking state, encoder
// decoder, event queue memory and the output register.
// ----------------------------------------------------------------------------
module kescan_dp
    import kescan_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [CFG_AW-1:0]   cfg_addr,
    input  logic [CFG_W-1:0]    cfg_wdata,
    input  logic [15:0]         in_levels,
    input  logic                in_enc_a,
    input  logic                in_enc_b,
    input  logic [TIME_W-1:0]   in_now,
    input  kescan_cmd_t         cmd,
    output kescan_stat_t        stat,
    input  logic                out_ready,
    output logic                out_valid,
    output logic                out_evt_valid,
    output logic [CODE_W-1:0]   out_code,
    output logic [KIND_W-1:0]   out_kind,
    output logic [LEFT_W-1:0]   out_left,
    output logic                out_ovf
);

    // configuration
    logic [15:0] mask_reg;
    logic [15:0] hold_reg;
    logic [15:0] long_reg;
    logic [1:0]  pulses_reg;
    logic [2:0]  enable_reg;

    // captured item
    logic [15:0]       levels_reg;
    logic              enc_a_reg;
    logic              enc_b_reg;
    logic [TIME_W-1:0] now_reg;

    // key tracking
    logic [TIME_W-1:0]   stamp_reg [NUM_KEYS];
    logic [NUM_KEYS-1:0] held_reg, held_next;
    logic [NUM_KEYS-1:0] lgiven_reg, lgiven_next;
    logic                stamp_we;

    // encoder
    logic       armed_reg, armed_next;
    logic [1:0] left_reg, left_next;
    logic [1:0] right_reg, right_next;

    // queue
    logic [ENTRY_W-1:0] mem [QUEUE_DEPTH];
    logic [ENTRY_W-1:0] rd_data_reg;
    logic [Q_AW-1:0]    head_reg, head_next;
    logic [QC_W-1:0]    count_reg, count_next;
    logic               ovf_reg, ovf_next;
    logic               hit_reg, hit_next;
    logic               mem_we;
    logic [Q_AW-1:0]    wr_addr;
    logic [Q_AW:0]      wr_sum;

    // event push request
    logic              push;
    logic [CODE_W-1:0] push_code;
    logic [KIND_W-1:0] push_kind;

    // per-key step
    logic [TIME_W-1:0] held_for;
    logic              k_down;
    logic              k_held;
    logic              k_lg;

    logic [1:0] left_inc;
    logic [1:0] right_inc;

    logic out_valid_reg, out_valid_next;

    assign stat.out_free = !out_valid_reg || out_ready;

    assign k_down   = !levels_reg[cmd.key_idx];
    assign k_held   = held_reg[cmd.key_idx];
    assign k_lg     = lgiven_reg[cmd.key_idx];
    assign held_for = now_reg - stamp_reg[cmd.key_idx];
    assign left_inc  = left_reg + 2'd1;
    assign right_inc = right_reg + 2'd1;

    always_comb begin
        held_next   = held_reg;
        lgiven_next = lgiven_reg;
        stamp_we    = 1'b0;
        armed_next  = armed_reg;
        left_next   = left_reg;
        right_next  = right_reg;
        push        = 1'b0;
        push_code   = CODE_W'(cmd.key_idx);
        push_kind   = KIND_PRESS;

        if (cmd.key_step && mask_reg[cmd.key_idx]) begin
            if (k_held) begin
                if (held_for > {16'd0, hold_reg}) begin
                    if (!k_down) begin
                        held_next[cmd.key_idx]   = 1'b0;
                        lgiven_next[cmd.key_idx] = 1'b0;
                        push      = !k_lg;
                        push_kind = KIND_RELEASE;
                    end else if (held_for > {16'd0, long_reg} && !k_lg) begin
                        lgiven_next[cmd.key_idx] = 1'b1;
                        push      = 1'b1;
                        push_kind = KIND_LONG;
                    end
                end
            end else if (k_down && !k_lg) begin
                held_next[cmd.key_idx] = 1'b1;
                stamp_we  = 1'b1;
                push      = 1'b1;
                push_kind = KIND_PRESS;
            end
        end

        if (cmd.enc_step) begin
            if (enc_a_reg && enc_b_reg) begin
                armed_next = 1'b1;
            end else if (armed_reg && enc_a_reg && !enc_b_reg) begin
                armed_next = 1'b0;
                if (left_inc == pulses_reg) begin
                    left_next = 2'd0;
                    push      = 1'b1;
                    push_code = CODE_LEFT;
                end else begin
                    left_next = left_inc;
                end
            end else if (armed_reg && !enc_a_reg && enc_b_reg) begin
                armed_next = 1'b0;
                if (right_inc == pulses_reg) begin
                    right_next = 2'd0;
                    push       = 1'b1;
                    push_code  = CODE_RIGHT;
                end else begin
                    right_next = right_inc;
                end
            end
        end
    end

    // queue write address wraps at the queue depth
    assign wr_sum  = {1'b0, head_reg} + count_reg[Q_AW-1:0];
    assign wr_addr = (wr_sum >= (Q_AW+1)'(QUEUE_DEPTH)) ?
                     Q_AW'(wr_sum - (Q_AW+1)'(QUEUE_DEPTH)) : wr_sum[Q_AW-1:0];

    always_comb begin
        mem_we     = 1'b0;
        head_next  = head_reg;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        hit_next   = hit_reg;
        if (push && enable_reg[push_kind]) begin
            if (count_reg == QC_W'(QUEUE_DEPTH)) begin
                ovf_next = 1'b1;
            end else begin
                mem_we     = 1'b1;
                count_next = count_reg + 1'b1;
            end
        end
        if (cmd.pop_rd) begin
            hit_next = (count_reg != '0);
            if (count_reg != '0) begin
                count_next = count_reg - 1'b1;
                head_next  = (head_reg == Q_AW'(QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;
            end
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg      <= RST_KEY_MASK;
            hold_reg      <= RST_HOLD_TIME;
            long_reg      <= RST_LONG_TIME;
            pulses_reg    <= RST_ENC_PULSES;
            enable_reg    <= RST_EVT_ENABLE;
            held_reg      <= '0;
            lgiven_reg    <= '0;
            armed_reg     <= 1'b0;
            left_reg      <= '0;
            right_reg     <= '0;
            head_reg      <= '0;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    REG_KEY_MASK:   mask_reg   <= cfg_wdata;
                    REG_HOLD_TIME:  hold_reg   <= cfg_wdata;
                    REG_LONG_TIME:  long_reg   <= cfg_wdata;
                    REG_ENC_PULSES: pulses_reg <= cfg_wdata[1:0];
                    REG_EVT_ENABLE: enable_reg <= cfg_wdata[2:0];
                    default: ;
                endcase
            end
            held_reg      <= held_next;
            lgiven_reg    <= lgiven_next;
            armed_reg     <= armed_next;
            left_reg      <= left_next;
            right_reg     <= right_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            hit_reg       <= hit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            levels_reg <= in_levels;
            enc_a_reg  <= in_enc_a;
            enc_b_reg  <= in_enc_b;
            now_reg    <= in_now;
        end
        if (stamp_we) begin
            stamp_reg[cmd.key_idx] <= now_reg;
        end
        if (cmd.out_load) begin
            out_evt_valid <= hit_reg;
            out_code      <= hit_reg ? rd_data_reg[ENTRY_W-1:KIND_W] : '0;
            out_kind      <= hit_reg ? rd_data_reg[KIND_W-1:0] : '0;
            out_left      <= LEFT_W'(count_reg);
            out_ovf       <= ovf_reg;
        end
    end

    // event queue memory
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[wr_addr] <= {push_code, push_kind};
        end
        if (cmd.pop_rd) begin
            rd_data_reg <= mem[head_reg];
        end
    end

    assign out_valid = out_valid_reg;

endmodule

@@ rtl/core/keypad_encoder_event_scanner_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keypad_encoder_event_scanner_top
// Key matrix and rotary encoder event scanner with a 128-entry event queue.
// ----------------------------------------------------------------------------
// The slave stream carries one item per transaction: tuser selects a scan
// tick (0) or a pop (1); tdata holds the key levels, encoder pins and the
// millisecond time. A scan tick walks the 16 key positions one per cycle,
// then steps the encoder decoder, and queues enabled events; it gives no
// output transaction and ready comes back after the encoder step.
// A pop reads the queue head from the event memory into a register and
// presents one master transaction (valid flag, code, kind, events left,
// overflow flag) from the output register once that register is free.
// One item is in work at a time: the next item is accepted only after the
// previous scan or pop has finished.
// A stalled master side holds the result in the output register; a scan
// can still run meanwhile, a following pop waits for the register to drain.
// Configuration writes (cfg_we, cfg_addr, cfg_wdata) take effect at once
// and are meant for idle periods. Reset restores the register defaults and
// clears key state, encoder state, queue pointers and the overflow flag.
// ----------------------------------------------------------------------------
module keypad_encoder_event_scanner_top
    import kescan_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic [CFG_AW-1:0] cfg_addr,
    input  logic [CFG_W-1:0]  cfg_wdata,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [55:0]       s_axis_tdata,   // key_levels, enc_a, enc_b, now_ms, zero pad
    input  logic [0:0]        s_axis_tuser,   // operation
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [15:0]       m_axis_tdata,   // event_code, events_left, overflowed, zero pad
    output logic [2:0]        m_axis_tuser    // event_valid, event_kind
);

    kescan_cmd_t  cmd;
    kescan_stat_t stat;

    logic              evt_valid;
    logic [CODE_W-1:0] evt_code;
    logic [KIND_W-1:0] evt_kind;
    logic [LEFT_W-1:0] evt_left;
    logic              evt_ovf;

    kescan_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_axis_tvalid),
        .in_op    (s_axis_tuser[0]),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    kescan_dp u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .in_levels     (s_axis_tdata[15:0]),
        .in_enc_a      (s_axis_tdata[16]),
        .in_enc_b      (s_axis_tdata[17]),
        .in_now        (s_axis_tdata[49:18]),
        .cmd           (cmd),
        .stat          (stat),
        .out_ready     (m_axis_tready),
        .out_valid     (m_axis_tvalid),
        .out_evt_valid (evt_valid),
        .out_code      (evt_code),
        .out_kind      (evt_kind),
        .out_left      (evt_left),
        .out_ovf       (evt_ovf)
    );

    assign m_axis_tdata = {2'b00, evt_ovf, evt_left, evt_code};
    assign m_axis_tuser = {evt_kind, evt_valid};

endmodule
